### rtl/core/dnh_pkg.sv
package dnh_pkg;

   localparam int NUM_SEEDS   = 4;
   localparam int CHUNK_WORDS = 8;
   localparam int ROUNDS      = 24;

   localparam logic [31:0] ROUND2_ADD = 32'h5A82_7999;
   localparam logic [31:0] ROUND3_ADD = 32'h6ED9_EBA1;
   localparam logic [31:0] EOF_HASH   = 32'hFFFF_FFFE;
   localparam logic [31:0] EOF_SUBST  = 32'hFFFF_FFFC;

   typedef logic [NUM_SEEDS-1:0][31:0]   word4_type;
   typedef logic [CHUNK_WORDS-1:0][31:0] word8_type;

   localparam word4_type MD4_IV = {32'h1032_5476, 32'h98BA_DCFE, 32'hEFCD_AB89, 32'h6745_2301};

   // one chunk of work handed from the front to the back
   typedef struct packed {
      logic      zero;   // zero-length name: emit hash of start buffer, no transform
      logic      load;   // first chunk of a name: start from the start buffer
      logic      last;   // last chunk: emit hash after the fold
      word4_type start;
      word8_type words;
   } job_type;

   function automatic word4_type load_start(input word4_type seeds);
      logic any;
      any = 1'b0;
      for (int i = 0; i < NUM_SEEDS; i++) begin
         if (seeds[i] != 32'h0) any = 1'b1;
      end
      return any ? seeds : MD4_IV;
   endfunction

   function automatic logic [31:0] final_hash(input logic [31:0] h);
      logic [31:0] m;
      m = {h[31:1], 1'b0};
      return (m == EOF_HASH) ? EOF_SUBST : m;
   endfunction

   function automatic logic [31:0] rep_byte(input logic [7:0] r);
      return {r, r, r, r};
   endfunction

   function automatic logic [2:0] word_sel(input logic [4:0] k);
      logic [2:0] s;
      unique case (k)
         5'd0:  s = 3'd0;  5'd1:  s = 3'd1;  5'd2:  s = 3'd2;  5'd3:  s = 3'd3;
         5'd4:  s = 3'd4;  5'd5:  s = 3'd5;  5'd6:  s = 3'd6;  5'd7:  s = 3'd7;
         5'd8:  s = 3'd1;  5'd9:  s = 3'd3;  5'd10: s = 3'd5;  5'd11: s = 3'd7;
         5'd12: s = 3'd0;  5'd13: s = 3'd2;  5'd14: s = 3'd4;  5'd15: s = 3'd6;
         5'd16: s = 3'd3;  5'd17: s = 3'd7;  5'd18: s = 3'd2;  5'd19: s = 3'd6;
         5'd20: s = 3'd1;  5'd21: s = 3'd5;  5'd22: s = 3'd0;  5'd23: s = 3'd4;
         default: s = 3'd0;
      endcase
      return s;
   endfunction

   function automatic logic [4:0] rot_amt(input logic [4:0] k);
      logic [4:0] s;
      unique case (k)
         5'd0, 5'd4, 5'd8, 5'd12, 5'd16, 5'd20: s = 5'd3;
         5'd1, 5'd5:                            s = 5'd7;
         5'd2, 5'd6, 5'd18, 5'd22:              s = 5'd11;
         5'd3, 5'd7:                            s = 5'd19;
         5'd9, 5'd13:                           s = 5'd5;
         5'd10, 5'd14, 5'd17, 5'd21:            s = 5'd9;
         5'd11, 5'd15:                          s = 5'd13;
         5'd19, 5'd23:                          s = 5'd15;
         default:                               s = 5'd3;
      endcase
      return s;
   endfunction

endpackage

### rtl/core/dnh_fifo.sv
module dnh_fifo #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en & ~full;
   assign do_rd   = rd_en & ~empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) wr_ptr_ff <= bump(wr_ptr_ff);
         if (do_rd) rd_ptr_ff <= bump(rd_ptr_ff);
         if (do_wr && !do_rd) count_ff <= count_ff + 1'b1;
         else if (do_rd && !do_wr) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

### rtl/core/dnh_front.sv
module dnh_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic [7:0]         req_name_byte,
   input  logic [7:0]         req_name_length,
   output logic               req_full,
   input  dnh_pkg::word4_type seeds,
   output logic               job_wr,
   output dnh_pkg::job_type   job_data,
   input  logic               job_full
);
   import dnh_pkg::*;

   logic [7:0]  bytes_taken_ff, bytes_taken_in;
   logic [31:0] partial_ff, partial_in;
   word8_type   words_ff, words_in;
   word4_type   start_ff, start_in;

   logic        accept, zero_len, first, last, chunk_end;
   logic [4:0]  pos;
   logic [7:0]  chunk_base;
   logic [31:0] pad, base_partial, packed_word, sx;
   word8_type   base_words;

   assign req_full = job_full;
   assign accept   = req_push & ~job_full;
   assign zero_len = (req_name_length == 8'd0);
   assign first    = (bytes_taken_ff == 8'd0);
   assign pos      = bytes_taken_ff[4:0];
   assign chunk_base = {bytes_taken_ff[7:5], 5'd0};
   // pad always follows the current beat's length
   assign pad      = rep_byte(req_name_length - chunk_base);
   assign last     = ({1'b0, bytes_taken_ff} + 9'd1) >= {1'b0, req_name_length};
   assign chunk_end = last | (pos == 5'd31);
   assign sx       = {{24{req_name_byte[7]}}, req_name_byte};

   always_comb begin
      base_words   = (pos == 5'd0) ? {CHUNK_WORDS{pad}} : words_ff;
      base_partial = (pos == 5'd0) ? pad : partial_ff;
      packed_word  = sx + (base_partial << 8);
      words_in     = base_words;
      partial_in   = packed_word;
      if (pos[1:0] == 2'd3) begin
         words_in[pos[4:2]] = packed_word;
         partial_in         = pad;
      end else if (chunk_end) begin
         words_in[pos[4:2]] = packed_word;
      end
      start_in = (zero_len || first) ? load_start(seeds) : start_ff;
      bytes_taken_in = (zero_len || last) ? 8'd0 : bytes_taken_ff + 8'd1;
   end

   assign job_wr         = accept & (zero_len | chunk_end);
   assign job_data.zero  = zero_len;
   assign job_data.load  = (bytes_taken_ff[7:5] == 3'd0);
   assign job_data.last  = last;
   assign job_data.start = start_in;
   assign job_data.words = words_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_taken_ff <= 8'd0;
      end else if (accept) begin
         bytes_taken_ff <= bytes_taken_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         start_ff <= start_in;
         if (!zero_len) begin
            words_ff   <= words_in;
            partial_ff <= partial_in;
         end
      end
   end

endmodule

### rtl/core/dnh_back.sv
module dnh_back (
   input  logic             clock,
   input  logic             reset,
   input  dnh_pkg::job_type job_data,
   input  logic             job_empty,
   output logic             job_rd,
   output logic             out_wr,
   output logic [31:0]      out_data,
   input  logic             out_full
);
   import dnh_pkg::*;

   typedef enum logic [1:0] {IDLE, ROUND, FOLD} state_type;

   state_type   state_ff;
   logic [4:0]  round_ff;
   word4_type   v_ff;      // rotating: [0] is the word updated this round
   word4_type   mix_ff;
   word8_type   words_ff;
   logic        last_ff;

   logic [31:0] x, y, z, f, w, acc, new_word;
   logic [63:0] rot_wide;
   word4_type   base, sum;

   assign x = v_ff[1];
   assign y = v_ff[2];
   assign z = v_ff[3];
   assign w = words_ff[word_sel(round_ff)];

   always_comb begin
      priority if (round_ff < 5'd8)  f = z ^ (x & (y ^ z));
      else if (round_ff < 5'd16)     f = ((x & y) | (x & z) | (y & z)) + ROUND2_ADD;
      else                           f = (x ^ y ^ z) + ROUND3_ADD;
      acc      = v_ff[0] + f + w;
      rot_wide = {acc, acc} << rot_amt(round_ff);
      new_word = rot_wide[63:32];
      for (int i = 0; i < NUM_SEEDS; i++) sum[i] = mix_ff[i] + v_ff[i];
      base = job_data.load ? job_data.start : mix_ff;
   end

   always_comb begin
      job_rd   = 1'b0;
      out_wr   = 1'b0;
      out_data = final_hash(sum[1]);
      unique case (state_ff)
         IDLE: begin
            if (!job_empty) begin
               if (job_data.zero) begin
                  job_rd   = ~out_full;
                  out_wr   = ~out_full;
                  out_data = final_hash(job_data.start[1]);
               end else begin
                  job_rd = 1'b1;
               end
            end
         end
         ROUND: ;
         FOLD: out_wr = last_ff & ~out_full;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         round_ff <= 5'd0;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (job_rd && !job_data.zero) begin
                  mix_ff   <= base;
                  v_ff     <= base;
                  words_ff <= job_data.words;
                  last_ff  <= job_data.last;
                  round_ff <= 5'd0;
                  state_ff <= ROUND;
               end
            end
            ROUND: begin
               v_ff <= {v_ff[2], v_ff[1], new_word, v_ff[3]};
               round_ff <= round_ff + 5'd1;
               if (round_ff == 5'(ROUNDS - 1)) state_ff <= FOLD;
            end
            FOLD: begin
               if (!last_ff || !out_full) begin
                  mix_ff   <= sum;
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

### rtl/core/dir_name_half_md4_hash_unit.sv
// Half-MD4 directory name hash, signed-byte variant. One name byte per beat.
// Front takes a byte every cycle unless the chunk queue is full; each 32-byte
// chunk (or shorter last chunk) passes the back end as a load, 24 rounds and
// a fold/emit. A zero-length beat yields its hash with no rounds.
// Synchronous active-high reset clears queues, control state and seeds.
module dir_name_half_md4_hash_unit #(
   parameter int JOB_DEPTH = 2,   // chunk queue between front and back, >= 2
   parameter int RSP_DEPTH = 2    // result queue, >= 2
) (
   input  logic        clock,
   input  logic        reset,
   // input beats
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_name_byte,
   input  logic [7:0]  req_name_length,
   // result beats
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_name_hash,
   // seed registers
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   import dnh_pkg::*;

   // seeds are sampled by the front when a name starts, so writes
   // during a name do not disturb it
   word4_type   seed_ff;

   job_type     front_job, back_job;
   logic        job_wr, job_full, job_rd, job_empty;
   logic        out_wr, out_full;
   logic [31:0] out_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (csr_write_enable) begin
         seed_ff[csr_index] <= csr_write_data;
      end
   end

   // front: packs bytes into chunk words, builds pad, cuts chunks
   dnh_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (push),
      .req_name_byte   (req_name_byte),
      .req_name_length (req_name_length),
      .req_full        (full),
      .seeds           (seed_ff),
      .job_wr          (job_wr),
      .job_data        (front_job),
      .job_full        (job_full)
   );

   // chunk queue: front keeps filling the next chunk while back mixes
   dnh_fifo #(
      .WIDTH ($bits(job_type)),
      .DEPTH (JOB_DEPTH)
   ) u_job_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_wr),
      .wr_data (front_job),
      .full    (job_full),
      .rd_en   (job_rd),
      .rd_data (back_job),
      .empty   (job_empty)
   );

   // back: one half-MD4 round per cycle, fold into mix buffer, emit hash
   dnh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_data  (back_job),
      .job_empty (job_empty),
      .job_rd    (job_rd),
      .out_wr    (out_wr),
      .out_data  (out_data),
      .out_full  (out_full)
   );

   // result queue decouples the consumer from the back end
   dnh_fifo #(
      .WIDTH (32),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (out_wr),
      .wr_data (out_data),
      .full    (out_full),
      .rd_en   (pop),
      .rd_data (rsp_name_hash),
      .empty   (empty)
   );

endmodule
